@@ rtl/arma11_pkg.sv @@
// Shared constants and saturation helpers for the ARMA(1,1) residual and gradient block.
`default_nettype none
package arma11_pkg;

    localparam int SAMPLE_W = 32;
    localparam int STATE_W  = 48;
    localparam int COEF_W   = 32;
    localparam int SUM_W    = 64;
    localparam int PROD_W   = 96;
    localparam int OBS_W    = 17;
    localparam int CFG_IDX_W = 2;
    localparam int LOG_W    = 36;
    localparam int OUT_DATA_W = 160;

    localparam logic [OBS_W-1:0] OBS_LIMIT = 17'd65535;

    localparam logic [CFG_IDX_W-1:0] REG_INTERCEPT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AR_COEFF  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MA_COEFF  = 2'd2;

    localparam logic signed [COEF_W-1:0] ONE_Q30     = 32'sh4000_0000;
    localparam logic signed [COEF_W-1:0] NEG_ONE_Q30 = 32'shC000_0000;
    localparam logic signed [65:0]       ONE_Q16_W   = 66'sd65536;
    localparam logic signed [65:0]       ONE_Q30_W   = 66'sd1073741824;
    localparam logic signed [47:0]       LN2_Q32     = 48'sd2977044472;
    localparam logic signed [47:0]       LOG2_Q16    = 48'sd17179869184;
    localparam logic signed [31:0]       NLL_MAX     = 32'sh7FFF_FFFF;
    localparam logic signed [31:0]       NLL_FLOOR   = -32'sd377921067;

    function automatic logic signed [63:0] sat64(input logic signed [95:0] x);
        if (x[95:63] == '0 || x[95:63] == '1) begin
            return x[63:0];
        end
        return x[95] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [65:0] x);
        if (x[65:47] == '0 || x[65:47] == '1) begin
            return x[47:0];
        end
        return x[65] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
        if (x[65:31] == '0 || x[65:31] == '1) begin
            return x[31:0];
        end
        return x[65] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
    endfunction

    function automatic logic signed [63:0] add_sat64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            return s[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
        end
        return s[63:0];
    endfunction

endpackage
`default_nettype wire

@@ rtl/arma11_mul.sv @@
// Shared signed 48 x 48 multiplier built from two 48 x 25 partial products, low half first.
`default_nettype none
module arma11_mul (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [47:0] i_a,
    input  wire logic signed [47:0] i_b,
    output logic                    o_done,
    output logic signed [95:0]      o_prod
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_HI   = 2'd1;
    localparam logic [1:0] PH_SUM  = 2'd2;

    logic [1:0]         r_phase;
    logic               r_done;
    logic signed [47:0] r_a;
    logic signed [24:0] r_bhi;
    logic signed [72:0] r_p;
    logic signed [72:0] r_lo;
    logic signed [95:0] r_prod;

    logic signed [47:0] w_ma;
    logic signed [24:0] w_mb;
    logic signed [72:0] w_p;

    always_comb begin
        w_ma = (r_phase == PH_IDLE) ? i_a : r_a;
        w_mb = (r_phase == PH_IDLE) ? $signed({1'b0, i_b[23:0]}) : r_bhi;
        w_p  = w_ma * w_mb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_phase)
                PH_IDLE: begin
                    if (i_start) begin
                        r_p     <= w_p;
                        r_a     <= i_a;
                        r_bhi   <= $signed({i_b[47], i_b[47:24]});
                        r_phase <= PH_HI;
                    end
                end
                PH_HI: begin
                    r_lo    <= r_p;
                    r_p     <= w_p;
                    r_phase <= PH_SUM;
                end
                PH_SUM: begin
                    r_prod  <= $signed({{23{r_lo[72]}}, r_lo})
                             + ($signed({{23{r_p[72]}}, r_p}) <<< 24);
                    r_done  <= 1'b1;
                    r_phase <= PH_IDLE;
                end
                default: r_phase <= PH_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_prod = r_prod;

endmodule
`default_nettype wire

@@ rtl/arma11_div.sv @@
// Restoring divider: signed 64-bit sum over unsigned 64-bit sum as saturated Q16.16.
`default_nettype none
module arma11_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [63:0] i_num,
    input  wire logic [63:0]        i_den,
    output logic                    o_done,
    output logic signed [31:0]      o_quot
);

    logic               r_busy;
    logic               r_done;
    logic               r_neg;
    logic [4:0]         r_cnt;
    logic [63:0]        r_rem;
    logic [63:0]        r_den;
    logic [30:0]        r_dig;
    logic [30:0]        r_q;
    logic signed [31:0] r_quot;

    logic [63:0] w_mag;
    logic [64:0] w_rr;
    logic        w_ge;
    logic [63:0] w_rem_next;
    logic [30:0] w_q_next;

    always_comb begin
        w_mag      = i_num[63] ? (64'd0 - i_num) : i_num;
        w_rr       = {r_rem, r_dig[30]};
        w_ge       = (w_rr >= {1'b0, r_den});
        w_rem_next = w_ge ? 64'(w_rr - {1'b0, r_den}) : w_rr[63:0];
        w_q_next   = {r_q[29:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_neg <= i_num[63];
                if (i_den == 64'd0) begin
                    // zero denominator: saturate toward the sign of the numerator, or give zero for a zero numerator
                    if (i_num == 64'sd0) begin
                        r_quot <= 32'sd0;
                    end else begin
                        r_quot <= i_num[63] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
                    end
                    r_done <= 1'b1;
                end else if ({15'b0, w_mag} >= {i_den, 15'b0}) begin
                    r_quot <= i_num[63] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
                    r_done <= 1'b1;
                end else begin
                    r_rem  <= {15'b0, w_mag[63:15]};
                    r_dig  <= {w_mag[14:0], 16'b0};
                    r_den  <= i_den;
                    r_q    <= '0;
                    r_cnt  <= '0;
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_rem <= w_rem_next;
                r_dig <= {r_dig[29:0], 1'b0};
                r_q   <= w_q_next;
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd30) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_quot <= r_neg ? $signed(32'd0 - {1'b0, w_q_next})
                                    : $signed({1'b0, w_q_next});
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule
`default_nettype wire

@@ rtl/arma11_residual_likelihood_gradient.sv @@
// ARMA(1,1) inverse filter with concentrated likelihood and gradient: sequencer and datapath.
// One sample is accepted at a time while the sequencer is idle; each accepted sample gives one
// result on the master stream, which is held in an output register so the next sample may be
// taken while a result waits. Each later sample of a series takes nine multiplications (five
// once the observation count reaches its limit) on the one shared multiplier. The sample
// marked tlast adds the summary unless the coefficients are out of range or the series is
// too short: two base-2 logarithms (a normalising shift, then 30 squarings on the multiplier)
// and one more multiplication, skipped when the sum of squares is zero, and three divisions on
// the serial divider. Configuration writes are always ready and take effect at once.
`default_nettype none
module arma11_residual_likelihood_gradient (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // configuration write channel
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [1:0]   i_cfg_index,
    input  wire logic [31:0]  i_cfg_data,
    // input stream
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [31:0]  s_axis_tdata,   // [31:0] sample
    input  wire logic         s_axis_tlast,   // end_of_series
    // result stream
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [31:0] residual, [63:32] neg_log_lik, [95:64] grad_intercept,
    // [127:96] grad_ar, [159:128] grad_ma
    output logic [159:0]      m_axis_tdata,
    output logic              m_axis_tlast,   // summary_valid
    output logic [1:0]        m_axis_tuser    // [0] coeff_out_of_range, [1] too_short
);

    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_M1   = 5'd1;
    localparam logic [4:0] ST_M2   = 5'd2;
    localparam logic [4:0] ST_S0   = 5'd3;
    localparam logic [4:0] ST_S1   = 5'd4;
    localparam logic [4:0] ST_S2   = 5'd5;
    localparam logic [4:0] ST_Q0   = 5'd6;
    localparam logic [4:0] ST_Q1   = 5'd7;
    localparam logic [4:0] ST_Q2   = 5'd8;
    localparam logic [4:0] ST_Q3   = 5'd9;
    localparam logic [4:0] ST_POST = 5'd10;
    localparam logic [4:0] ST_NORM = 5'd11;
    localparam logic [4:0] ST_SQR  = 5'd12;
    localparam logic [4:0] ST_LN   = 5'd13;
    localparam logic [4:0] ST_DIV0 = 5'd14;
    localparam logic [4:0] ST_DIV1 = 5'd15;
    localparam logic [4:0] ST_DIV2 = 5'd16;
    localparam logic [4:0] ST_OUT  = 5'd17;

    logic [4:0] r_state;
    logic [4:0] n_state;

    logic signed [31:0] r_cc, r_ar, r_ma;
    logic               r_started;
    logic signed [31:0] r_prev_sample;
    logic signed [47:0] r_prev_res;
    logic signed [47:0] r_sens_int, r_sens_ar, r_sens_ma;
    logic signed [63:0] r_sum_sq, r_sum_int, r_sum_ar, r_sum_ma;
    logic [arma11_pkg::OBS_W-1:0] r_obs;

    logic signed [31:0] r_smp;
    logic               r_last, r_bad, r_gate, r_short;
    logic signed [47:0] r_res;
    logic signed [63:0] r_m1;
    logic signed [31:0] r_nll, r_g0, r_g1, r_g2;

    logic [63:0]        r_x;
    logic [5:0]         r_k;
    logic [29:0]        r_frac;
    logic [4:0]         r_it;
    logic               r_which;
    logic [arma11_pkg::LOG_W-1:0] r_logs;

    logic                r_out_valid;
    logic [159:0]        r_out_data;
    logic                r_out_last;
    logic [1:0]          r_out_user;

    logic                mul_start, mul_done;
    logic signed [47:0]  mul_a, mul_b;
    logic signed [95:0]  mul_prod;
    logic                div_start, div_done;
    logic signed [63:0]  div_g;
    logic signed [31:0]  div_q;

    logic signed [63:0] w_m, w_q, w_lnv;
    logic signed [65:0] w_t;
    logic signed [31:0] w_nll;
    logic [31:0]        w_sq;
    logic [30:0]        w_m_next;
    logic [29:0]        w_frac_next;
    logic [arma11_pkg::LOG_W-1:0] w_log_new;
    logic signed [47:0] w_d;
    logic               w_bad, w_short, w_out_free;

    arma11_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    arma11_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_g),
        .i_den   (r_sum_sq),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    always_comb begin
        w_m         = arma11_pkg::sat64(mul_prod >>> 30);
        w_q         = arma11_pkg::sat64(mul_prod >>> 16);
        w_lnv       = arma11_pkg::sat64(mul_prod >>> 32);
        w_t         = $signed({{2{w_lnv[63]}}, w_lnv}) + arma11_pkg::ONE_Q30_W;
        w_nll       = arma11_pkg::sat32(w_t >>> 7);
        w_sq        = mul_prod[61:30];
        w_m_next    = w_sq[31] ? w_sq[31:1] : w_sq[30:0];
        w_frac_next = {r_frac[28:0], w_sq[31]};
        w_log_new   = {r_k, w_frac_next};
        w_d         = $signed({12'b0, r_logs}) - arma11_pkg::LOG2_Q16
                    - $signed({12'b0, w_log_new});
        w_bad       = (r_ar >= arma11_pkg::ONE_Q30) || (r_ar <= arma11_pkg::NEG_ONE_Q30)
                   || (r_ma >= arma11_pkg::ONE_Q30) || (r_ma <= arma11_pkg::NEG_ONE_Q30);
        w_short     = (r_obs == '0);
        w_out_free  = !r_out_valid || m_axis_tready;
    end

    // sequencer: next state and operand selection for the shared units
    always_comb begin
        n_state   = r_state;
        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        div_g     = r_sum_int;
        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    if (r_started) begin
                        mul_start = 1'b1;
                        mul_a     = $signed({{16{r_prev_sample[31]}}, r_prev_sample});
                        mul_b     = $signed({{16{r_ar[31]}}, r_ar});
                        n_state   = ST_M1;
                    end else begin
                        n_state = ST_POST;
                    end
                end
            end
            ST_M1: begin
                if (mul_done) begin
                    mul_start = 1'b1;
                    mul_a     = r_prev_res;
                    mul_b     = $signed({{16{r_ma[31]}}, r_ma});
                    n_state   = ST_M2;
                end
            end
            ST_M2: begin
                if (mul_done) begin
                    mul_start = 1'b1;
                    mul_a     = r_sens_int;
                    mul_b     = $signed({{16{r_ma[31]}}, r_ma});
                    n_state   = ST_S0;
                end
            end
            ST_S0: begin
                if (mul_done) begin
                    mul_start = 1'b1;
                    mul_a     = r_sens_ar;
                    mul_b     = $signed({{16{r_ma[31]}}, r_ma});
                    n_state   = ST_S1;
                end
            end
            ST_S1: begin
                if (mul_done) begin
                    mul_start = 1'b1;
                    mul_a     = r_sens_ma;
                    mul_b     = $signed({{16{r_ma[31]}}, r_ma});
                    n_state   = ST_S2;
                end
            end
            ST_S2: begin
                if (mul_done) begin
                    if (r_gate) begin
                        mul_start = 1'b1;
                        mul_a     = r_res;
                        mul_b     = r_res;
                        n_state   = ST_Q0;
                    end else begin
                        n_state = ST_POST;
                    end
                end
            end
            ST_Q0: begin
                if (mul_done) begin
                    mul_start = 1'b1;
                    mul_a     = r_res;
                    mul_b     = r_sens_int;
                    n_state   = ST_Q1;
                end
            end
            ST_Q1: begin
                if (mul_done) begin
                    mul_start = 1'b1;
                    mul_a     = r_res;
                    mul_b     = r_sens_ar;
                    n_state   = ST_Q2;
                end
            end
            ST_Q2: begin
                if (mul_done) begin
                    mul_start = 1'b1;
                    mul_a     = r_res;
                    mul_b     = r_sens_ma;
                    n_state   = ST_Q3;
                end
            end
            ST_Q3: begin
                if (mul_done) begin
                    n_state = ST_POST;
                end
            end
            ST_POST: begin
                if (!r_last || r_bad || w_short) begin
                    n_state = ST_OUT;
                end else if (r_sum_sq == 64'sd0) begin
                    div_start = 1'b1;
                    n_state   = ST_DIV0;
                end else begin
                    n_state = ST_NORM;
                end
            end
            ST_NORM: begin
                if (r_x[63]) begin
                    mul_start = 1'b1;
                    mul_a     = $signed({17'b0, r_x[63:33]});
                    mul_b     = $signed({17'b0, r_x[63:33]});
                    n_state   = ST_SQR;
                end
            end
            ST_SQR: begin
                if (mul_done) begin
                    if (r_it == 5'd29) begin
                        if (!r_which) begin
                            n_state = ST_NORM;
                        end else begin
                            mul_start = 1'b1;
                            mul_a     = w_d;
                            mul_b     = arma11_pkg::LN2_Q32;
                            n_state   = ST_LN;
                        end
                    end else begin
                        mul_start = 1'b1;
                        mul_a     = $signed({17'b0, w_m_next});
                        mul_b     = $signed({17'b0, w_m_next});
                    end
                end
            end
            ST_LN: begin
                if (mul_done) begin
                    div_start = 1'b1;
                    n_state   = ST_DIV0;
                end
            end
            ST_DIV0: begin
                if (div_done) begin
                    div_start = 1'b1;
                    div_g     = r_sum_ar;
                    n_state   = ST_DIV1;
                end
            end
            ST_DIV1: begin
                if (div_done) begin
                    div_start = 1'b1;
                    div_g     = r_sum_ma;
                    n_state   = ST_DIV2;
                end
            end
            ST_DIV2: begin
                if (div_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_cc          <= '0;
            r_ar          <= '0;
            r_ma          <= '0;
            r_started     <= 1'b0;
            r_prev_sample <= '0;
            r_prev_res    <= '0;
            r_sens_int    <= '0;
            r_sens_ar     <= '0;
            r_sens_ma     <= '0;
            r_sum_sq      <= '0;
            r_sum_int     <= '0;
            r_sum_ar      <= '0;
            r_sum_ma      <= '0;
            r_obs         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid) begin
                case (i_cfg_index)
                    arma11_pkg::REG_INTERCEPT: r_cc <= i_cfg_data;
                    arma11_pkg::REG_AR_COEFF:  r_ar <= i_cfg_data;
                    arma11_pkg::REG_MA_COEFF:  r_ma <= i_cfg_data;
                    default: ;
                endcase
            end

            // the output state reloads the register itself
            if (r_out_valid && m_axis_tready && (r_state != ST_OUT)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_smp   <= s_axis_tdata;
                        r_last  <= s_axis_tlast;
                        r_bad   <= w_bad;
                        r_gate  <= (r_obs < arma11_pkg::OBS_LIMIT);
                        r_short <= 1'b0;
                        r_nll   <= '0;
                        r_g0    <= '0;
                        r_g1    <= '0;
                        r_g2    <= '0;
                        if (!r_started) begin
                            r_started <= 1'b1;
                            r_res     <= '0;
                        end
                    end
                end
                ST_M1: begin
                    if (mul_done) begin
                        r_m1 <= w_m;
                    end
                end
                ST_M2: begin
                    if (mul_done) begin
                        r_res <= arma11_pkg::sat48($signed(
                                     {{34{r_smp[31]}}, r_smp} - {{34{r_cc[31]}}, r_cc}
                                   - {{2{r_m1[63]}}, r_m1} - {{2{w_m[63]}}, w_m}));
                    end
                end
                ST_S0: begin
                    if (mul_done) begin
                        r_sens_int <= arma11_pkg::sat48(
                            -arma11_pkg::ONE_Q16_W - $signed({{2{w_m[63]}}, w_m}));
                    end
                end
                ST_S1: begin
                    if (mul_done) begin
                        r_sens_ar <= arma11_pkg::sat48($signed(
                            66'd0 - {{34{r_prev_sample[31]}}, r_prev_sample}
                                  - {{2{w_m[63]}}, w_m}));
                    end
                end
                ST_S2: begin
                    if (mul_done) begin
                        r_sens_ma <= arma11_pkg::sat48($signed(
                            66'd0 - {{18{r_prev_res[47]}}, r_prev_res}
                                  - {{2{w_m[63]}}, w_m}));
                    end
                end
                ST_Q0: begin
                    if (mul_done) begin
                        r_sum_sq <= arma11_pkg::add_sat64(r_sum_sq, w_q);
                    end
                end
                ST_Q1: begin
                    if (mul_done) begin
                        r_sum_int <= arma11_pkg::add_sat64(r_sum_int, w_q);
                    end
                end
                ST_Q2: begin
                    if (mul_done) begin
                        r_sum_ar <= arma11_pkg::add_sat64(r_sum_ar, w_q);
                    end
                end
                ST_Q3: begin
                    if (mul_done) begin
                        r_sum_ma <= arma11_pkg::add_sat64(r_sum_ma, w_q);
                        r_obs    <= r_obs + 17'd1;
                    end
                end
                ST_POST: begin
                    r_prev_res    <= r_res;
                    r_prev_sample <= r_smp;
                    if (r_last) begin
                        r_short <= w_short;
                        if (r_bad || w_short) begin
                            r_nll <= arma11_pkg::NLL_MAX;
                        end else if (r_sum_sq == 64'sd0) begin
                            r_nll <= arma11_pkg::NLL_FLOOR;
                        end else begin
                            r_x     <= r_sum_sq;
                            r_k     <= 6'd63;
                            r_which <= 1'b0;
                        end
                    end
                end
                ST_NORM: begin
                    if (r_x[63]) begin
                        r_it   <= '0;
                        r_frac <= '0;
                    end else if (r_x[63:56] == 8'd0) begin
                        r_x <= {r_x[55:0], 8'd0};
                        r_k <= r_k - 6'd8;
                    end else begin
                        r_x <= {r_x[62:0], 1'b0};
                        r_k <= r_k - 6'd1;
                    end
                end
                ST_SQR: begin
                    if (mul_done) begin
                        r_frac <= w_frac_next;
                        r_it   <= r_it + 5'd1;
                        if (r_it == 5'd29 && !r_which) begin
                            // hold log2 of the sum, then take log2 of the count
                            r_logs  <= w_log_new;
                            r_which <= 1'b1;
                            r_x     <= {47'd0, r_obs};
                            r_k     <= 6'd63;
                        end
                    end
                end
                ST_LN: begin
                    if (mul_done) begin
                        r_nll <= w_nll;
                    end
                end
                ST_DIV0: begin
                    if (div_done) begin
                        r_g0 <= div_q;
                    end
                end
                ST_DIV1: begin
                    if (div_done) begin
                        r_g1 <= div_q;
                    end
                end
                ST_DIV2: begin
                    if (div_done) begin
                        r_g2 <= div_q;
                    end
                end
                ST_OUT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= {r_g2, r_g1, r_g0, r_nll,
                                        arma11_pkg::sat32($signed({{18{r_res[47]}}, r_res}))};
                        r_out_last  <= r_last;
                        r_out_user  <= {r_short, r_bad};
                        if (r_last) begin
                            // close the series
                            r_started     <= 1'b0;
                            r_prev_sample <= '0;
                            r_prev_res    <= '0;
                            r_sens_int    <= '0;
                            r_sens_ar     <= '0;
                            r_sens_ma     <= '0;
                            r_sum_sq      <= '0;
                            r_sum_int     <= '0;
                            r_sum_ar      <= '0;
                            r_sum_ma      <= '0;
                            r_obs         <= '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_user;

endmodule
`default_nettype wire

@@ dv/testbench.sv @@
// Self-checking testbench for the ARMA(1,1) residual, likelihood and gradient block.
`timescale 1ns / 1ps

typedef struct {
    logic [31:0] residual;
    logic        summary_valid;
    logic        coeff_bad;
    logic        too_short;
    logic [31:0] neg_log_lik;
    logic [31:0] grad_c;
    logic [31:0] grad_phi;
    logic [31:0] grad_theta;
} t_arma_result;

class arma_scoreboard;
    longint      reg_c, reg_phi, reg_theta;
    bit          open_series;
    longint      last_y, last_e, de_dc, de_dphi, de_dtheta;
    longint      sq_sum, sum_c, sum_phi, sum_theta;
    int unsigned n_obs;
    t_arma_result pending[$];
    int          errors;

    function void clear_series();
        open_series = 0;
        last_y = 0; last_e = 0;
        de_dc = 0; de_dphi = 0; de_dtheta = 0;
        sq_sum = 0; sum_c = 0; sum_phi = 0; sum_theta = 0;
        n_obs = 0;
    endfunction

    function void reset_all();
        reg_c = 0; reg_phi = 0; reg_theta = 0;
        errors = 0;
        pending.delete();
        clear_series();
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] val);
        if (idx == arma11_pkg::REG_INTERCEPT) reg_c = longint'($signed(val));
        else if (idx == arma11_pkg::REG_AR_COEFF) reg_phi = longint'($signed(val));
        else if (idx == arma11_pkg::REG_MA_COEFF) reg_theta = longint'($signed(val));
    endfunction

    static function longint clip(longint x, int w);
        longint hi, lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        return x > hi ? hi : (x < lo ? lo : x);
    endfunction

    static function longint add_s(longint a, longint b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s[64] != s[63]) return s[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
        return s[63:0];
    endfunction

    static function longint neg_s(longint x);
        return x == 64'sh8000_0000_0000_0000 ? 64'sh7FFF_FFFF_FFFF_FFFF : -x;
    endfunction

    // floor(a*b / 2^sh), saturated to 64 bits
    static function longint mul_shift(longint a, longint b, int sh);
        logic signed [127:0] pa, pb, p;
        pa = a;
        pb = b;
        p = (pa * pb) >>> sh;
        if (p[127:63] != '0 && p[127:63] != '1)
            return p[127] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
        return p[63:0];
    endfunction

    static function longint log2_q30(bit [63:0] x);
        int k;
        bit [63:0] m, frac;
        k = 63;
        frac = 0;
        while (k > 0 && !x[k]) k--;
        m = k >= 30 ? x >> (k - 30) : x << (30 - k);
        for (int i = 0; i < 30; i++) begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd2 << 30)) begin
                m = m >> 1;
                frac[0] = 1'b1;
            end
        end
        return longint'((64'(k) << 30) | frac);
    endfunction

    static function longint quotient_q16(longint g, bit [63:0] s);
        bit        neg;
        bit [63:0] ug, q, r;
        neg = g < 0;
        ug = neg ? 64'(-g) : 64'(g);
        if (s == 0) return g > 0 ? 32'sh7FFF_FFFF : (g < 0 ? -64'sd2147483648 : 0);
        q = ug / s;
        if (q >= 32768) return neg ? -64'sd2147483648 : 64'sd2147483647;
        r = ug % s;
        for (int i = 0; i < 16; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= s) begin
                r = r - s;
                q[0] = 1'b1;
            end
        end
        return neg ? -longint'(q) : longint'(q);
    endfunction

    // Filter one accepted sample and queue the result it should produce
    function void note_sample(logic [31:0] y_raw, logic eos);
        t_arma_result r;
        longint y, e, acc, s0, s1, s2, nll, g0, g1, g2, d;
        bit bad, short_ser;
        y = longint'($signed(y_raw));
        bad = reg_phi >= 64'sd1073741824 || reg_phi <= -64'sd1073741824 ||
              reg_theta >= 64'sd1073741824 || reg_theta <= -64'sd1073741824;
        e = 0; nll = 0; g0 = 0; g1 = 0; g2 = 0; short_ser = 0;
        if (open_series) begin
            acc = add_s(y, -reg_c);
            acc = add_s(acc, neg_s(mul_shift(last_y, reg_phi, 30)));
            acc = add_s(acc, neg_s(mul_shift(last_e, reg_theta, 30)));
            e = clip(acc, arma11_pkg::STATE_W);
            s0 = clip(add_s(-64'sd65536, neg_s(mul_shift(de_dc, reg_theta, 30))),
                      arma11_pkg::STATE_W);
            s1 = clip(add_s(neg_s(last_y), neg_s(mul_shift(de_dphi, reg_theta, 30))),
                      arma11_pkg::STATE_W);
            s2 = clip(add_s(neg_s(last_e), neg_s(mul_shift(de_dtheta, reg_theta, 30))),
                      arma11_pkg::STATE_W);
            de_dc = s0; de_dphi = s1; de_dtheta = s2;
            if (n_obs < arma11_pkg::OBS_LIMIT) begin
                sq_sum    = add_s(sq_sum, mul_shift(e, e, 16));
                sum_c     = add_s(sum_c, mul_shift(e, s0, 16));
                sum_phi   = add_s(sum_phi, mul_shift(e, s1, 16));
                sum_theta = add_s(sum_theta, mul_shift(e, s2, 16));
                n_obs++;
            end
            last_e = e;
        end else begin
            open_series = 1;
        end
        last_y = y;
        if (eos) begin
            short_ser = n_obs == 0;
            if (bad || short_ser) begin
                nll = arma11_pkg::NLL_MAX;
            end else begin
                if (sq_sum == 0) begin
                    nll = arma11_pkg::NLL_FLOOR;
                end else begin
                    d = log2_q30(sq_sum) - (longint'(16) <<< 30) - log2_q30(64'(n_obs));
                    nll = clip(add_s(mul_shift(d, longint'(arma11_pkg::LN2_Q32), 32),
                                     64'sd1073741824) >>> 7, 32);
                end
                g0 = quotient_q16(sum_c, sq_sum);
                g1 = quotient_q16(sum_phi, sq_sum);
                g2 = quotient_q16(sum_theta, sq_sum);
            end
            clear_series();
        end
        r.residual = clip(e, arma11_pkg::SAMPLE_W);
        r.summary_valid = eos;
        r.coeff_bad = bad;
        r.too_short = short_ser;
        r.neg_log_lik = nll;
        r.grad_c = g0;
        r.grad_phi = g1;
        r.grad_theta = g2;
        pending.push_back(r);
    endfunction

    function void report(string field, logic [31:0] want, logic [31:0] got);
        $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
        errors++;
    endfunction

    function void check_result(t_arma_result got);
        t_arma_result want;
        if (pending.size() == 0) begin
            $display("%0t: result with none outstanding: residual %h", $time, got.residual);
            errors++;
            return;
        end
        want = pending.pop_front();
        if (got.residual !== want.residual)
            report("residual", want.residual, got.residual);
        if (got.summary_valid !== want.summary_valid)
            report("summary_valid", want.summary_valid, got.summary_valid);
        if (got.coeff_bad !== want.coeff_bad)
            report("coeff_out_of_range", want.coeff_bad, got.coeff_bad);
        if (got.too_short !== want.too_short)
            report("too_short", want.too_short, got.too_short);
        if (got.neg_log_lik !== want.neg_log_lik)
            report("neg_log_lik", want.neg_log_lik, got.neg_log_lik);
        if (got.grad_c !== want.grad_c)
            report("grad_intercept", want.grad_c, got.grad_c);
        if (got.grad_phi !== want.grad_phi)
            report("grad_ar", want.grad_phi, got.grad_phi);
        if (got.grad_theta !== want.grad_theta)
            report("grad_ma", want.grad_theta, got.grad_theta);
    endfunction
endclass

module testbench;
    localparam int STALL_LIMIT = 5000;
    localparam int ITEM_TARGET = 1350;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [1:0]   i_cfg_index;
    logic [31:0]  i_cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [31:0]  s_axis_tdata;
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [159:0] m_axis_tdata;
    logic         m_axis_tlast;
    logic [1:0]   m_axis_tuser;

    arma_scoreboard sb;
    int  items_sent;
    bit  calm;
    int  quiet_cycles;
    int  stall_left;

    arma11_residual_likelihood_gradient dut (.*);

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    // drop tready in random bursts until the calm tail of the run
    always @(negedge i_clk) begin
        if (calm || !i_rst_n) begin
            m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 9);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_arma_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.residual      = m_axis_tdata[31:0];
            got.neg_log_lik   = m_axis_tdata[63:32];
            got.grad_c        = m_axis_tdata[95:64];
            got.grad_phi      = m_axis_tdata[127:96];
            got.grad_theta    = m_axis_tdata[159:128];
            got.summary_valid = m_axis_tlast;
            got.coeff_bad     = m_axis_tuser[0];
            got.too_short     = m_axis_tuser[1];
            sb.check_result(got);
        end
    end

    // count cycles with no transaction on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: timeout, %0d results outstanding", $time, sb.pending.size());
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_coeffs(logic [31:0] c, logic [31:0] phi, logic [31:0] theta);
        wait_idle();
        write_reg(arma11_pkg::REG_INTERCEPT, c);
        write_reg(arma11_pkg::REG_AR_COEFF, phi);
        write_reg(arma11_pkg::REG_MA_COEFF, theta);
    endtask

    // leave tvalid high between back-to-back samples; only lower it for a gap
    task automatic send_sample(logic [31:0] y, logic eos);
        int gap;
        gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= y;
        s_axis_tlast  <= eos;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_sample(y, eos);
        items_sent++;
    endtask

    function automatic logic [31:0] rand_sample();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return 32'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
            2: return 32'($urandom_range(0, 32'h0400_0000)) - 32'h0200_0000;
            default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 3)
                                                  : 32'h8000_0000 + $urandom_range(0, 3);
        endcase
    endfunction

    function automatic logic [31:0] rand_coeff();
        case ($urandom_range(0, 11))
            0: return $urandom();
            1: return $urandom_range(0, 1) ? 32'h3FFF_FFFF : 32'hC000_0001;
            2: return $urandom_range(0, 1) ? arma11_pkg::ONE_Q30 : arma11_pkg::NEG_ONE_Q30;
            3: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            4: return 32'h0;
            default: return 32'($urandom_range(0, 32'h7A00_0000)) - 32'h3D00_0000;
        endcase
    endfunction

    task automatic run_series(int len);
        for (int i = 0; i < len; i++) send_sample(rand_sample(), i == len - 1);
    endtask

    initial begin
        int len;
        sb = new();
        sb.reset_all();
        items_sent = 0;
        calm = 0;
        stall_left = 0;
        quiet_cycles = 0;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b1;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: one-sample series, zero sum of squares, field extremes
        send_sample(32'h0001_0000, 1'b1);
        send_sample(32'h0, 1'b0);
        send_sample(32'h0, 1'b0);
        send_sample(32'h0, 1'b1);
        send_sample(32'h7FFF_FFFF, 1'b0);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'h7FFF_FFFF, 1'b0);
        send_sample(32'hFFFF_FFFF, 1'b1);
        set_coeffs(32'h8000_0000, 32'h3FFF_FFFF, 32'hC000_0001);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'h7FFF_FFFF, 1'b0);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'h7FFF_FFFF, 1'b1);
        set_coeffs(32'h7FFF_FFFF, arma11_pkg::ONE_Q30, arma11_pkg::NEG_ONE_Q30);
        send_sample(32'h0002_0000, 1'b0);
        send_sample(32'hFFFE_0000, 1'b1);
        send_sample(32'h0003_0000, 1'b1);
        wait_idle();
        write_reg(2'd3, 32'hFFFF_FFFF);
        write_reg(arma11_pkg::REG_AR_COEFF, 32'h2000_0000);
        write_reg(arma11_pkg::REG_MA_COEFF, 32'h1000_0000);
        write_reg(arma11_pkg::REG_INTERCEPT, 32'h0000_8000);
        // short series under nonzero intercept, AR and MA coefficients
        send_sample(32'h0001_0000, 1'b0);
        send_sample(32'h0000_C000, 1'b0);
        send_sample(32'h0000_8000, 1'b0);
        send_sample(32'h0001_0000, 1'b1);

        while (items_sent < ITEM_TARGET) begin
            if (items_sent > ITEM_TARGET * 85 / 100) calm = 1;
            wait_idle();
            if ($urandom_range(0, 4) == 0) write_reg(2'd3, $urandom());
            write_reg(arma11_pkg::REG_INTERCEPT, $urandom_range(0, 2) == 0 ? $urandom()
                      : 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000);
            write_reg(arma11_pkg::REG_AR_COEFF, rand_coeff());
            write_reg(arma11_pkg::REG_MA_COEFF, rand_coeff());
            repeat ($urandom_range(2, 6)) begin
                len = $urandom_range(0, 7) == 0 ? $urandom_range(1, 2) : $urandom_range(3, 40);
                if (items_sent < ITEM_TARGET) run_series(len);
            end
        end

        wait_idle();
        repeat (400) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

@@ sim.f @@
rtl/arma11_pkg.sv
rtl/arma11_mul.sv
rtl/arma11_div.sv
rtl/arma11_residual_likelihood_gradient.sv
dv/testbench.sv
